// File: rtl/core/binary_threshold_xnor_dot_engine_top_assert.svh
// Assertion macros for the binary threshold xnor dot engine.
`ifndef BINARY_THRESHOLD_XNOR_DOT_ENGINE_TOP_ASSERT_SVH
`define BINARY_THRESHOLD_XNOR_DOT_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define BTX_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Condition that, once seen, must be followed by a consequence.
`define BTX_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
`else
`define BTX_ASSERT(label, clk, rst, prop)
`define BTX_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/btx_pkg.sv
// Shared constants, codes and types of the binary threshold xnor dot engine.
`timescale 1ns / 1ps
`default_nettype none
package btx_pkg;

   // Sizing of the engine
   localparam int MAX_CHANNELS  = 16;
   localparam int MAX_PATCH_LEN = 1024;

   // Fixed field widths
   localparam int OPC_W      = 2;
   localparam int CHAN_W     = 6;
   localparam int POS_W      = 10;
   localparam int VAL_W      = 8;
   localparam int COEF_W     = 16;
   localparam int RES_W      = 32;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 7;

   // Derived widths
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int USED_W = $clog2(MAX_CHANNELS + 1);
   localparam int ADDR_W = (MAX_PATCH_LEN > 1) ? $clog2(MAX_PATCH_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_PATCH_LEN + 1);
   localparam int ACC_W  = CNT_W + 1;
   localparam int PROD_W = ACC_W + COEF_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int TW_W   = VAL_W + 1;

   // Reset value of the channel count register
   localparam logic [CFG_DATA_W-1:0] CHANNELS_RESET = CFG_DATA_W'(16);

   // Q8 unity, used when scaling is off
   localparam logic signed [COEF_W-1:0] Q8_ONE = COEF_W'(256);

   // Saturation bounds of the result
   localparam logic signed [63:0] RES_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] RES_MIN = -64'sh0000_0000_8000_0000;

   typedef enum logic [OPC_W-1:0] {
      OPC_LOAD_THR   = 2'd0,
      OPC_LOAD_SCALE = 2'd1,
      OPC_ELEMENT    = 2'd2
   } opcode_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_CHANNELS  = 2'd0,
      REG_SCALE_EN  = 2'd1,
      REG_RELU_EN   = 2'd2
   } reg_index_type;

   // Broadcast from the control section to every cell
   typedef struct packed {
      logic                     thr_wr;
      logic                     coef_wr;
      logic [CHAN_W-1:0]        ld_channel;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [VAL_W-1:0]  thr;
      logic                     wbit;
      logic signed [COEF_W-1:0] scale;
      logic signed [COEF_W-1:0] shift;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
      logic                     s1_accum;
      logic                     s1_last;
      logic signed [VAL_W-1:0]  s1_value;
      logic                     load_chain;
      logic                     shift_chain;
      logic [USED_W-1:0]        used;
   } bcast_type;

   // One slot of the result shift chain
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic [CHAN_W-1:0]        ch;
      logic signed [ACC_W-1:0]  acc;
      logic signed [COEF_W-1:0] scale;
      logic signed [COEF_W-1:0] shift;
   } slot_type;

   // Multiply stage of the finish unit
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic [CHAN_W-1:0]        ch;
      logic signed [PROD_W-1:0] prod;
      logic signed [COEF_W-1:0] shift;
   } mul_type;

endpackage
`default_nettype wire

// File: rtl/core/btx_if.sv
// Request, response and register write channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface btx_req_if import btx_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPC_W-1:0]         opcode;
   logic [CHAN_W-1:0]        channel;
   logic [POS_W-1:0]         position;
   logic signed [VAL_W-1:0]  threshold;
   logic                     weight_bit;
   logic signed [COEF_W-1:0] scale;
   logic signed [COEF_W-1:0] shift;
   logic signed [VAL_W-1:0]  patch_value;
   logic                     last_element;

   modport source (output valid, opcode, channel, position, threshold, weight_bit,
                   scale, shift, patch_value, last_element, input ready);
   modport sink   (input valid, opcode, channel, position, threshold, weight_bit,
                   scale, shift, patch_value, last_element, output ready);
endinterface

interface btx_rsp_if import btx_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CHAN_W-1:0]       out_channel;
   logic signed [RES_W-1:0] value;
   logic                    last_of_run;

   modport source (output valid, out_channel, value, last_of_run, input ready);
   modport sink   (input valid, out_channel, value, last_of_run, output ready);
endinterface

interface btx_csr_if import btx_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CFG_IDX_W-1:0]  reg_index;
   logic [CFG_DATA_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/btx_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module btx_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/core/btx_cell.sv
// One channel cell: threshold memory, accumulator and result chain slot.
`timescale 1ns / 1ps
`default_nettype none
module btx_cell import btx_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [CH_W-1:0] cell_index,
   input  wire bcast_type       bc,
   input  wire slot_type        slot_next,
   output slot_type             slot_out
);

   logic                     thr_we;
   logic [TW_W-1:0]          tw_rd;
   logic signed [VAL_W-1:0]  thr_rd;
   logic                     hit;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_sum, acc_fin;
   logic signed [ACC_W-1:0]  fin_ff;
   logic signed [COEF_W-1:0] scale_ff, shift_ff;
   slot_type                 slot_ff, slot_in, slot_new;
   logic                     mine;

   assign mine   = (bc.ld_channel == CHAN_W'(cell_index));
   assign thr_we = bc.thr_wr && mine;

   // Threshold and weight bit per patch position
   btx_ram #(
      .WIDTH (TW_W),
      .DEPTH (MAX_PATCH_LEN)
   ) u_tw_ram (
      .clock (clock),
      .we    (thr_we),
      .waddr (bc.wr_addr),
      .wdata ({bc.wbit, bc.thr}),
      .re    (bc.rd_en),
      .raddr (bc.rd_addr),
      .rdata (tw_rd)
   );

   // Compare, xnor with weight and step the accumulator
   assign thr_rd  = tw_rd[VAL_W-1:0];
   assign hit     = (thr_rd > bc.s1_value) ^ tw_rd[VAL_W];
   assign acc_sum = hit ? (acc_ff + ACC_W'(1)) : (acc_ff - ACC_W'(1));
   assign acc_fin = bc.s1_accum ? acc_sum : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (bc.s1_last) begin
         acc_in = '0;
      end else if (bc.s1_accum) begin
         acc_in = acc_sum;
      end
   end

   // Snapshot for the chain load
   always_comb begin
      slot_new.valid = USED_W'(cell_index) < bc.used;
      slot_new.last  = (USED_W'(cell_index) + USED_W'(1)) == bc.used;
      slot_new.ch    = CHAN_W'(cell_index);
      slot_new.acc   = fin_ff;
      slot_new.scale = scale_ff;
      slot_new.shift = shift_ff;
   end

   // Chain slot: load from the snapshot, else shift toward the head
   always_comb begin
      slot_in = slot_ff;
      if (bc.load_chain) begin
         slot_in = slot_new;
      end else if (bc.shift_chain) begin
         slot_in = slot_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         slot_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         slot_ff <= slot_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (bc.s1_last) begin
         fin_ff <= acc_fin;
      end
      if (bc.coef_wr && mine) begin
         scale_ff <= bc.scale;
         shift_ff <= bc.shift;
      end
   end

   assign slot_out = slot_ff;

endmodule
`default_nettype wire

// File: rtl/core/btx_finish.sv
// Finish unit: scale, shift, saturate and ReLU, then the response register.
`timescale 1ns / 1ps
`default_nettype none
module btx_finish import btx_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire slot_type head,
   input  wire logic     scale_en,
   input  wire logic     relu_en,
   output logic          head_take,
   btx_rsp_if.source     rsp
);

   mul_type                  mul_ff, mul_in;
   logic signed [COEF_W-1:0] mult;
   logic signed [SUM_W-1:0]  sum;
   logic signed [63:0]       wide;
   logic signed [63:0]       sat;
   logic                     out_v_ff;
   logic [CHAN_W-1:0]        out_ch_ff;
   logic signed [RES_W-1:0]  out_val_ff;
   logic                     out_last_ff;
   logic                     out_rdy, mul_rdy;

   // Backpressure through the two stages
   assign out_rdy   = !out_v_ff || rsp.ready;
   assign mul_rdy   = !mul_ff.valid || out_rdy;
   assign head_take = head.valid && mul_rdy;

   // Multiply stage: acc times scale, or times one in Q8
   assign mult = scale_en ? head.scale : Q8_ONE;

   always_comb begin
      mul_in       = mul_ff;
      if (mul_rdy) begin
         mul_in.valid = head.valid;
         mul_in.last  = head.last;
         mul_in.ch    = head.ch;
         mul_in.prod  = head.acc * mult;
         mul_in.shift = scale_en ? head.shift : '0;
      end
   end

   // Add, saturate to 32 bits, clamp negatives when ReLU is on
   assign sum  = mul_ff.prod + mul_ff.shift;
   assign wide = 64'(sum);

   always_comb begin
      sat = wide;
      if (wide > RES_MAX) begin
         sat = RES_MAX;
      end else if (wide < RES_MIN) begin
         sat = RES_MIN;
      end
      if (relu_en && sat < 0) begin
         sat = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         mul_ff <= mul_in;
         if (out_rdy) begin
            out_v_ff <= mul_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && mul_ff.valid) begin
         out_ch_ff   <= mul_ff.ch;
         out_val_ff  <= sat[RES_W-1:0];
         out_last_ff <= mul_ff.last;
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.out_channel = out_ch_ff;
   assign rsp.value       = out_val_ff;
   assign rsp.last_of_run = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/core/binary_threshold_xnor_dot_engine_top.sv
// Top level of the binary threshold xnor dot engine.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_threshold_xnor_dot_engine_top_assert.svh"
// The engine takes one request per cycle when ready: threshold loads, scale
// loads and patch elements all enter back to back, and every element
// updates all channel cells at once (one memory read, compare, xnor and
// +/-1 per cell). A request marked last blocks the request channel while
// its final sums settle in the cells, then until the result chain has
// emptied the previous patch, which drains one channel per cycle toward
// the finish unit as it takes them. Results pass through the multiply and
// response registers and leave one per cycle, in channel order, while the
// response side takes them. Stores need no clearing after reset; unwritten
// threshold, weight, scale and shift entries read as anything.
module binary_threshold_xnor_dot_engine_top import btx_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   btx_req_if.sink   req_chan,
   btx_rsp_if.source rsp_chan,
   btx_csr_if.sink   csr_chan
);

   logic [CFG_DATA_W-1:0]   chans_ff;
   logic                    scale_en_ff, relu_en_ff;
   logic [USED_W-1:0]       used;
   logic                    req_accept;
   logic                    is_elem, ch_ok, pos_ok;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    acc_en;
   logic                    s1_accum_ff, s1_last_ff;
   logic signed [VAL_W-1:0] s1_value_ff;
   logic                    pend_ff, pend_in;
   logic                    load_chain;
   logic                    head_take;
   bcast_type               bc;
   slot_type                slots [MAX_CHANNELS+1];
   logic [MAX_CHANNELS-1:0] chain_v, chain_l;

   // Register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chans_ff    <= CHANNELS_RESET;
         scale_en_ff <= 1'b0;
         relu_en_ff  <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            REG_CHANNELS: chans_ff    <= csr_chan.wr_data;
            REG_SCALE_EN: scale_en_ff <= csr_chan.wr_data[0];
            REG_RELU_EN:  relu_en_ff  <= csr_chan.wr_data[0];
            default: ;
         endcase
      end
   end

   assign used = (chans_ff > CFG_DATA_W'(MAX_CHANNELS)) ? USED_W'(MAX_CHANNELS)
                                                        : USED_W'(chans_ff);

   // Request decode
   assign req_chan.ready = !pend_ff && !s1_last_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign is_elem        = req_accept && (req_chan.opcode == OPC_ELEMENT);
   assign ch_ok          = 32'(req_chan.channel) < MAX_CHANNELS;
   assign pos_ok         = 32'(req_chan.position) < MAX_PATCH_LEN;
   assign acc_en         = cnt_ff < CNT_W'(MAX_PATCH_LEN);

   // Element position counter, saturating at the patch limit
   always_comb begin
      cnt_in = cnt_ff;
      if (is_elem) begin
         if (req_chan.last_element) begin
            cnt_in = '0;
         end else if (acc_en) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // A finished patch waits here until the result chain is empty
   assign load_chain = pend_ff && !slots[0].valid;

   always_comb begin
      pend_in = pend_ff;
      if (s1_last_ff) begin
         pend_in = 1'b1;
      end else if (load_chain) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_accum_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_accum_ff <= is_elem && acc_en;
         s1_last_ff  <= is_elem && req_chan.last_element;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_elem) begin
         s1_value_ff <= req_chan.patch_value;
      end
   end

   // Broadcast to the cells
   always_comb begin
      bc.thr_wr      = req_accept && (req_chan.opcode == OPC_LOAD_THR) && ch_ok && pos_ok;
      bc.coef_wr     = req_accept && (req_chan.opcode == OPC_LOAD_SCALE) && ch_ok;
      bc.ld_channel  = req_chan.channel;
      bc.wr_addr     = ADDR_W'(req_chan.position);
      bc.thr         = req_chan.threshold;
      bc.wbit        = req_chan.weight_bit;
      bc.scale       = req_chan.scale;
      bc.shift       = req_chan.shift;
      bc.rd_en       = is_elem;
      bc.rd_addr     = ADDR_W'(cnt_ff);
      bc.s1_accum    = s1_accum_ff;
      bc.s1_last     = s1_last_ff;
      bc.s1_value    = s1_value_ff;
      bc.load_chain  = load_chain;
      bc.shift_chain = head_take;
      bc.used        = used;
   end

   // Row of channel cells; results shift toward cell zero
   assign slots[MAX_CHANNELS] = '0;

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
      btx_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CH_W'(i)),
         .bc         (bc),
         .slot_next  (slots[i+1]),
         .slot_out   (slots[i])
      );
      assign chain_v[i] = slots[i].valid;
      assign chain_l[i] = slots[i].valid && slots[i].last;
   end

   btx_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .head      (slots[0]),
      .scale_en  (scale_en_ff),
      .relu_en   (relu_en_ff),
      .head_take (head_take),
      .rsp       (rsp_chan)
   );

   // Checks
   `BTX_ASSERT(a_chain_prefix, clock, reset,
      (chain_v & (chain_v + MAX_CHANNELS'(1))) == '0)
   `BTX_ASSERT(a_chain_one_last, clock, reset, $onehot0(chain_l))
   `BTX_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(MAX_PATCH_LEN))
   `BTX_ASSERT_IMPL(a_no_accept_pending, clock, reset, pend_ff, !req_accept)
   `BTX_ASSERT_IMPL(a_load_fills_head, clock, reset, $past(load_chain) && !$past(reset),
      chain_v[0] == (used != '0))

endmodule
`default_nettype wire

// File: tb/binary_threshold_xnor_dot_engine_top_tb.sv
// Self-checking testbench for the binary threshold xnor dot engine.
`timescale 1ns / 1ps
`default_nettype none
module binary_threshold_xnor_dot_engine_top_tb;
   import btx_pkg::*;

   // Codes the package leaves unnamed
   localparam logic [OPC_W-1:0]     OPC_RESERVED = 2'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

   localparam int     SETTLE_CYCLES = 24;   // chain drain plus finish pipeline
   localparam int     KNOWN_LEN     = 2;    // positions the directed patches reach
   localparam int     REFILL_LEN    = 8;    // positions given random content
   localparam int     PHASE_ITEMS   = 80;
   localparam int     CONFIG_EVERY  = 30;
   localparam int     MAX_PRINTED   = 40;
   localparam longint TIMEOUT_NS    = 5_000_000;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [CHAN_W-1:0] channel;
      logic [POS_W-1:0]  position;
      logic [VAL_W-1:0]  threshold;
      logic              weight_bit;
      logic [COEF_W-1:0] scale;
      logic [COEF_W-1:0] shift;
      logic [VAL_W-1:0]  patch_value;
      logic              last_element;
   } request_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [RES_W-1:0]  value;
      logic              last;
   } result_type;

   typedef enum bit {ROW_REQ, ROW_REG} row_kind_type;

   // One directed row: a is threshold / scale / activation / register data,
   // b is shift, flag is weight bit or last mark
   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        code;
      logic [CHAN_W-1:0] channel;
      logic [POS_W-1:0]  position;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic              flag;
      logic              checked;
      logic [RES_W-1:0]  typed_value;
   } step_type;

   // Positions zero and one start as threshold -128, weight 1: each element adds +1
   localparam int NUM_DIRECTED = 24;
   localparam step_type DIRECTED_STEPS [NUM_DIRECTED] = '{
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd0,     16'sd0,     1'b1, 1'b1, 32'sd256},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    -16'sd128,  16'sd0,     1'b1, 1'b1, 32'sd512},
      '{ROW_REG, REG_SPARE,      6'd0,  10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_RESERVED,   6'd63, 10'd1023, -16'sd1,    -16'sd1,    1'b1, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_LOAD_THR,   6'd63, 10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_LOAD_THR,   6'd16, 10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_LOAD_SCALE, 6'd63, 10'd0,    -16'sd32768, -16'sd32768, 1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd0,     16'sd0,     1'b1, 1'b1, 32'sd256},
      '{ROW_REG, REG_CHANNELS,   6'd0,  10'd0,    16'sd0,     16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd5,     16'sd0,     1'b1, 1'b0, 32'sd0},
      '{ROW_REG, REG_CHANNELS,   6'd0,  10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    -16'sd5,    16'sd0,     1'b1, 1'b1, 32'sd256},
      '{ROW_REG, REG_CHANNELS,   6'd0,  10'd0,    16'sd1,     16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REG, REG_SCALE_EN,   6'd0,  10'd0,    16'sd1,     16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_LOAD_SCALE, 6'd0,  10'd0,    16'sd32767, 16'sd32767, 1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd0,     16'sd0,     1'b1, 1'b1, 32'sd65534},
      '{ROW_REQ, OPC_LOAD_SCALE, 6'd0,  10'd0,    -16'sd32768, -16'sd32768, 1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd0,     16'sd0,     1'b1, 1'b1, -32'sd65536},
      '{ROW_REQ, OPC_LOAD_THR,   6'd0,  10'd0,    16'sd127,   16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd127,   16'sd0,     1'b1, 1'b1, 32'sd0},
      '{ROW_REG, REG_RELU_EN,    6'd0,  10'd0,    16'sd1,     16'sd0,     1'b0, 1'b0, 32'sd0},
      '{ROW_REQ, OPC_ELEMENT,    6'd0,  10'd0,    16'sd126,   16'sd0,     1'b1, 1'b1, 32'sd0},
      '{ROW_REQ, OPC_LOAD_THR,   6'd15, 10'd1023, -16'sd128,  16'sd0,     1'b1, 1'b0, 32'sd0}
   };

   logic clock = 1'b0;
   logic reset;

   btx_req_if req_bus ();
   btx_rsp_if rsp_bus ();
   btx_csr_if csr_bus ();

   binary_threshold_xnor_dot_engine_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the engine state
   logic signed [VAL_W-1:0]  thr_mem   [MAX_CHANNELS][MAX_PATCH_LEN];
   bit                       wgt_mem   [MAX_CHANNELS][MAX_PATCH_LEN];
   logic signed [COEF_W-1:0] scale_mem [MAX_CHANNELS];
   logic signed [COEF_W-1:0] shift_mem [MAX_CHANNELS];
   int                       acc_mem   [MAX_CHANNELS];
   int                       elem_count;
   logic [CFG_DATA_W-1:0]    chan_cfg;
   bit                       scale_on;
   bit                       relu_on;

   result_type channel_results_due [$];

   int req_gap_pct;
   int rsp_stall_pct;
   int error_count;
   int useful_requests;
   int patch_count;
   int reg_writes;
   int results_checked;

   task automatic flag_error(input string msg);
      if (error_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Q8 output of one channel after scaling, saturation and clamping
   function automatic logic [RES_W-1:0] finish_value(input int c);
      longint v;
      if (scale_on) v = longint'(acc_mem[c]) * longint'(scale_mem[c]) + longint'(shift_mem[c]);
      else v = longint'(acc_mem[c]) * longint'(Q8_ONE);
      if (v > RES_MAX) v = RES_MAX;
      if (v < RES_MIN) v = RES_MIN;
      if (relu_on && v < 0) v = 0;
      return v[RES_W-1:0];
   endfunction

   // Apply one request to the mirror; collect the channel results it emits
   function automatic void compute_channel_results(input request_type r,
                                                   ref result_type outs [$]);
      int used;
      bit hit;
      case (r.opcode)
         OPC_LOAD_THR: begin
            if (r.channel < MAX_CHANNELS && r.position < MAX_PATCH_LEN) begin
               thr_mem[r.channel][r.position] = r.threshold;
               wgt_mem[r.channel][r.position] = r.weight_bit;
            end
         end
         OPC_LOAD_SCALE: begin
            if (r.channel < MAX_CHANNELS) begin
               scale_mem[r.channel] = r.scale;
               shift_mem[r.channel] = r.shift;
            end
         end
         OPC_ELEMENT: begin
            // elements past the patch limit are dropped, counter holds
            if (elem_count < MAX_PATCH_LEN) begin
               for (int c = 0; c < MAX_CHANNELS; c++) begin
                  hit = (thr_mem[c][elem_count] > $signed(r.patch_value)) ^ wgt_mem[c][elem_count];
                  acc_mem[c] += hit ? 1 : -1;
               end
               elem_count++;
            end
            if (r.last_element) begin
               used = (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_cfg);
               for (int c = 0; c < used; c++)
                  outs.push_back('{CHAN_W'(c), finish_value(c), c == used - 1});
               foreach (acc_mem[c]) acc_mem[c] = 0;
               elem_count = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // Wait until every result is in and the block has settled
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (channel_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
      wait_idle();
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_CHANNELS: chan_cfg = data;
         REG_SCALE_EN: scale_on = data[0];
         REG_RELU_EN:  relu_on  = data[0];
         default: ;
      endcase
      reg_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   // Drive one request; valid stays high into the next call unless it idles
   task automatic send_request(input request_type r, input bit typed = 1'b0,
                               input logic [RES_W-1:0] typed_value = '0);
      result_type outs [$];
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= r.opcode;
      req_bus.channel      <= r.channel;
      req_bus.position     <= r.position;
      req_bus.threshold    <= r.threshold;
      req_bus.weight_bit   <= r.weight_bit;
      req_bus.scale        <= r.scale;
      req_bus.shift        <= r.shift;
      req_bus.patch_value  <= r.patch_value;
      req_bus.last_element <= r.last_element;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      compute_channel_results(r, outs);
      foreach (outs[i]) begin
         if (typed) outs[i].value = typed_value;
         channel_results_due.push_back(outs[i]);
      end
      if (r.opcode != OPC_RESERVED &&
          !(r.opcode != OPC_ELEMENT && r.channel >= MAX_CHANNELS)) useful_requests++;
      if (r.opcode == OPC_ELEMENT && r.last_element) patch_count++;
   endtask

   function automatic request_type noise_request();
      return request_type'({$urandom, $urandom, $urandom});
   endfunction

   // Activations biased toward the compare edges
   function automatic logic [VAL_W-1:0] pick_activation();
      case ($urandom_range(0, 7))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic fill_stores(input bit scramble, input int depth);
      request_type r;
      for (int p = 0; p < depth; p++) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            r = noise_request();
            r.opcode     = OPC_LOAD_THR;
            r.channel    = CHAN_W'(c);
            r.position   = POS_W'(p);
            r.threshold  = scramble ? VAL_W'($urandom) : 8'h80;
            r.weight_bit = scramble ? 1'($urandom) : 1'b1;
            send_request(r);
         end
      end
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         r = noise_request();
         r.opcode  = OPC_LOAD_SCALE;
         r.channel = CHAN_W'(c);
         r.scale   = scramble ? COEF_W'($urandom) : Q8_ONE;
         r.shift   = scramble ? COEF_W'($urandom) : '0;
         send_request(r);
      end
   endtask

   task automatic shuffle_config();
      logic [CFG_DATA_W-1:0] count;
      case ($urandom_range(0, 7))
         0: count = '0;
         1: count = 7'd1;
         2: count = CFG_DATA_W'(MAX_CHANNELS);
         3: count = 7'd17;
         4: count = 7'd64;
         5: count = '1;
         default: count = CFG_DATA_W'($urandom_range(1, MAX_CHANNELS));
      endcase
      write_register(REG_CHANNELS, count);
      write_register(REG_SCALE_EN, CFG_DATA_W'($urandom));
      write_register(REG_RELU_EN, CFG_DATA_W'($urandom));
   endtask

   // Mostly complete patches with fresh loads; the rest is stray traffic
   task automatic run_random_sequence();
      request_type r;
      int          len;
      if ($urandom_range(0, 99) < 75) begin
         repeat ($urandom_range(0, 3)) begin
            r = noise_request();
            r.opcode   = OPC_LOAD_THR;
            r.channel  = CHAN_W'($urandom_range(0, MAX_CHANNELS - 1));
            r.position = POS_W'($urandom_range(0, REFILL_LEN - 1));
            send_request(r);
         end
         if ($urandom_range(0, 3) == 0) begin
            r = noise_request();
            r.opcode  = OPC_LOAD_SCALE;
            r.channel = CHAN_W'($urandom_range(0, MAX_CHANNELS - 1));
            if ($urandom_range(0, 3) == 0) r.scale = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            send_request(r);
         end
         // patch stays inside the positions with loaded content
         len = int'($urandom_range(1, REFILL_LEN - elem_count));
         for (int i = 0; i < len; i++) begin
            r = noise_request();
            r.opcode       = OPC_ELEMENT;
            r.patch_value  = pick_activation();
            r.last_element = (i == len - 1);
            send_request(r);
         end
      end else begin
         r = noise_request();
         case ($urandom_range(0, 4))
            0: r.opcode = OPC_RESERVED;
            1: begin
               r.opcode  = OPC_LOAD_THR;
               r.channel = CHAN_W'($urandom_range(MAX_CHANNELS, 63));
            end
            2: begin
               r.opcode  = OPC_LOAD_SCALE;
               r.channel = CHAN_W'($urandom_range(MAX_CHANNELS, 63));
            end
            3: begin
               // any position, in range channel
               r.opcode  = OPC_LOAD_THR;
               r.channel = CHAN_W'($urandom_range(0, MAX_CHANNELS - 1));
            end
            default: begin
               r.opcode = OPC_ELEMENT;
               // close the patch before it runs past the loaded positions
               if (elem_count >= REFILL_LEN - 1) r.last_element = 1'b1;
            end
         endcase
         send_request(r);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (channel_results_due.size() == 0) begin
         flag_error($sformatf("unexpected result ch %0d value %0d", rsp_bus.out_channel,
                              rsp_bus.value));
         return;
      end
      want = channel_results_due.pop_front();
      if (rsp_bus.out_channel !== want.channel)
         flag_error($sformatf("channel got %0d want %0d", rsp_bus.out_channel, want.channel));
      if (rsp_bus.value !== want.value)
         flag_error($sformatf("ch %0d value got %0d want %0d", want.channel, rsp_bus.value,
                              $signed(want.value)));
      if (rsp_bus.last_of_run !== want.last)
         flag_error($sformatf("ch %0d last got %b want %b", want.channel,
                              rsp_bus.last_of_run, want.last));
      results_checked++;
   endtask

   // Result side: check each accepted result, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      step_type    s;
      request_type r;
      int          phase_start;
      int          last_config;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.channel      = '0;
      req_bus.position     = '0;
      req_bus.threshold    = '0;
      req_bus.weight_bit   = 1'b0;
      req_bus.scale        = '0;
      req_bus.shift        = '0;
      req_bus.patch_value  = '0;
      req_bus.last_element = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.reg_index    = '0;
      csr_bus.wr_data      = '0;
      foreach (acc_mem[c]) acc_mem[c] = 0;
      elem_count = 0;
      chan_cfg   = CHANNELS_RESET;
      scale_on   = 1'b0;
      relu_on    = 1'b0;
      req_gap_pct   = 37;
      rsp_stall_pct = 56;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Known contents at the positions the directed patches reach
      fill_stores(1'b0, KNOWN_LEN);

      // Directed rows
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         s = DIRECTED_STEPS[i];
         if (s.kind == ROW_REG) begin
            write_register(s.code, s.a[CFG_DATA_W-1:0]);
         end else begin
            r = noise_request();
            r.opcode       = s.code;
            r.channel      = s.channel;
            r.position     = s.position;
            r.threshold    = s.a[VAL_W-1:0];
            r.weight_bit   = s.flag;
            r.scale        = s.a;
            r.shift        = s.b;
            r.patch_value  = s.a[VAL_W-1:0];
            r.last_element = s.flag;
            send_request(r, s.checked, s.typed_value);
         end
      end

      // Random content for the low positions and all scales
      fill_stores(1'b1, REFILL_LEN);

      // Random traffic under three idle profiles
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct   = 37;
               rsp_stall_pct = 56;
            end
            1: begin
               req_gap_pct   = 56;
               rsp_stall_pct = 37;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         shuffle_config();
         phase_start = useful_requests;
         last_config = useful_requests;
         while (useful_requests - phase_start < PHASE_ITEMS) begin
            if (useful_requests - last_config >= CONFIG_EVERY) begin
               shuffle_config();
               last_config = useful_requests;
            end
            run_random_sequence();
         end
      end

      wait_idle();
      $display("Run covered %0d requests in %0d patches and %0d register writes,",
               useful_requests, patch_count, reg_writes);
      $display("with %0d channel results checked and %0d errors", results_checked,
               error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: binary_threshold_xnor_dot_engine_top.f
+incdir+rtl/core
rtl/core/btx_pkg.sv
rtl/core/btx_if.sv
rtl/core/btx_ram.sv
rtl/core/btx_cell.sv
rtl/core/btx_finish.sv
rtl/core/binary_threshold_xnor_dot_engine_top.sv
tb/binary_threshold_xnor_dot_engine_top_tb.sv
